@@ rtl/trsd_pkg.sv @@
// ----------------------------------------------------------------------------
// trsd_pkg: shared types and codes for the touch slider direction core
// Item structs, mode, step and register index codes.
// ----------------------------------------------------------------------------
package trsd_pkg;

  localparam int ReadingW   = 16;
  localparam int LevelW     = 8;
  localparam int PadIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;

  localparam logic [1:0] MODE_CAPTURE = 2'd0;
  localparam logic [1:0] MODE_SENSE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_TOUCH_THRESHOLD    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS_STEP    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_BRIGHTNESS = 2'd2;

  localparam logic [ReadingW-1:0] THRESHOLD_RST = 16'd100;
  localparam logic [LevelW-1:0]   STEP_RST      = 8'd10;
  localparam logic [LevelW-1:0]   INIT_RST      = 8'd128;

  typedef struct packed {
    logic [1:0]          mode;
    logic [PadIdxW-1:0]  pad_index;
    logic [ReadingW-1:0] reading;
    logic                last_pad;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic [1:0]        step_taken;
  } out_item_t;

endpackage

@@ rtl/touch_ring_slider_direction_core.sv @@
// ----------------------------------------------------------------------------
// touch_ring_slider_direction_core: capacitive slider direction decoder
// Tracks touched pads across scans and steps a brightness level up or down.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_data): one pad reading per item,
//     with mode (capture, sense, clear), pad index and end-of-scan mark.
//   out channel (out_valid / out_stall / out_data): exactly one result item
//     per input item: brightness after the item and the step direction.
//   cfg port (cfg_we / cfg_index / cfg_data): threshold, step and initial
//     brightness; write only while the core is idle.
// The item is evaluated in the accept cycle and the result appears from the
// output register on the next cycle. An item can be accepted every cycle
// while the receiver does not stall; the rate is set by the single output
// register, which is refilled in the same cycle it is drained.
// When the receiver stalls with a result pending, in_stall rises and the
// pending result holds until taken.
// Reset (synchronous, active high) restores the register defaults, sets the
// level to 128 and forgets all touches. Baselines are not cleared; capture
// every pad before sensing it.
// ----------------------------------------------------------------------------
module touch_ring_slider_direction_core
  import trsd_pkg::*;
#(
  parameter int PADS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int IdxW = (PADS > 1) ? $clog2(PADS) : 1;
  localparam logic [PadIdxW:0]   PadCount = (PadIdxW+1)'(PADS);
  localparam logic [PadIdxW-1:0] LastPad  = PadIdxW'(PADS - 1);

  // configuration
  logic [ReadingW-1:0] touch_threshold;
  logic [LevelW-1:0]   brightness_step;
  logic [LevelW-1:0]   initial_brightness;

  // tracking state
  logic [ReadingW-1:0] pad_baseline [PADS];
  logic [PadIdxW-1:0]  first_pad, first_pad_next;
  logic                first_valid, first_valid_next;
  logic [PadIdxW-1:0]  second_pad, second_pad_next;
  logic                second_valid, second_valid_next;
  logic [LevelW-1:0]   level, level_next;
  logic [1:0]          step_next;

  logic                accept;
  logic                in_range;
  logic [IdxW-1:0]     base_idx;
  logic [ReadingW-1:0] base;
  logic [ReadingW-1:0] diff;
  logic                touched;
  logic [PadIdxW-1:0]  fp1, sp1;
  logic                fv1, sv1;
  logic                up;
  logic [LevelW:0]     raised_sum;
  logic [LevelW-1:0]   raised, lowered;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  assign in_range = {1'b0, in_data.pad_index} < PadCount;
  assign base_idx = in_data.pad_index[IdxW-1:0];
  assign base     = pad_baseline[base_idx];
  assign diff     = (in_data.reading > base) ? (in_data.reading - base)
                                             : (base - in_data.reading);
  assign touched  = in_range && (diff > touch_threshold);

  assign raised_sum = {1'b0, level} + {1'b0, brightness_step};
  assign raised     = raised_sum[LevelW] ? {LevelW{1'b1}} : raised_sum[LevelW-1:0];
  assign lowered    = (level > brightness_step) ? (level - brightness_step) : '0;

  // touch capture, ahead of end-of-scan evaluation
  always_comb begin
    fp1 = first_pad;
    fv1 = first_valid;
    sp1 = second_pad;
    sv1 = second_valid;
    if (touched) begin
      if (!first_valid) begin
        fp1 = in_data.pad_index;
        fv1 = 1'b1;
      end else if (first_pad != in_data.pad_index) begin
        sp1 = in_data.pad_index;
        sv1 = 1'b1;
      end
    end
  end

  // wraparound between last pad and pad 0 reverses the plain order rule
  always_comb begin
    if (fp1 > sp1) begin
      up = (fp1 == LastPad) && (sp1 == '0);
    end else begin
      up = !((fp1 == '0) && (sp1 == LastPad));
    end
  end

  always_comb begin
    first_pad_next    = first_pad;
    first_valid_next  = first_valid;
    second_pad_next   = second_pad;
    second_valid_next = second_valid;
    level_next        = level;
    step_next         = STEP_NONE;
    unique case (in_data.mode)
      MODE_CAPTURE: begin
        level_next        = initial_brightness;
        first_valid_next  = 1'b0;
        second_valid_next = 1'b0;
      end
      MODE_CLEAR: begin
        first_valid_next  = 1'b0;
        second_valid_next = 1'b0;
      end
      MODE_SENSE: begin
        first_pad_next    = fp1;
        first_valid_next  = fv1;
        second_pad_next   = sp1;
        second_valid_next = sv1;
        if (in_data.last_pad && fv1 && sv1 && (fp1 != sp1)) begin
          if (up) begin
            level_next = raised;
            step_next  = STEP_UP;
          end else begin
            level_next = lowered;
            step_next  = STEP_DOWN;
          end
          first_pad_next    = sp1;
          second_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_threshold    <= THRESHOLD_RST;
      brightness_step    <= STEP_RST;
      initial_brightness <= INIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOUCH_THRESHOLD:    touch_threshold    <= cfg_data;
        REG_BRIGHTNESS_STEP:    brightness_step    <= cfg_data[LevelW-1:0];
        REG_INITIAL_BRIGHTNESS: initial_brightness <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.mode == MODE_CAPTURE) && in_range) begin
      pad_baseline[base_idx] <= in_data.reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid  <= 1'b0;
      second_valid <= 1'b0;
      level        <= INIT_RST;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        first_valid  <= first_valid_next;
        second_valid <= second_valid_next;
        level        <= level_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_pad           <= first_pad_next;
      second_pad          <= second_pad_next;
      out_data.brightness <= level_next;
      out_data.step_taken <= step_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    second_valid |-> first_valid)
    else $error("second touch held without a first");

  a_pads_differ: assert property (@(posedge clk) disable iff (rst)
    (first_valid && second_valid) |-> (first_pad != second_pad))
    else $error("first and second touch on the same pad");

  a_capture_loads_level: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.mode == MODE_CAPTURE) |=>
      (out_data.brightness == $past(initial_brightness) &&
       out_data.step_taken == STEP_NONE))
    else $error("capture did not load the initial brightness");
`endif

endmodule
